// ----- design/bdha_pkg.sv -----
// ----------------------------------------------------------------------------
// bdha_pkg
// shared constants, register codes and configuration type for the button
// debouncer with joystick hysteresis and autorepeat
// ----------------------------------------------------------------------------
`default_nettype none

package bdha_pkg;

    localparam int NUM_BUTTONS = 5;
    localparam int NUM_HELD    = 9;
    localparam int RAW_W       = 5;
    localparam int AXIS_W      = 12;
    localparam int LVL_W       = 8;
    localparam int CNT_W       = 16;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 16;

    localparam logic [LVL_W-1:0] STEP_DOWN = 8'd1;

    localparam int BIT_RIGHT = 5;
    localparam int BIT_LEFT  = 6;
    localparam int BIT_UP    = 7;
    localparam int BIT_DOWN  = 8;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PRESSED_LEVEL  = 3'd0,
        REG_STEP_UP        = 3'd1,
        REG_UPPER_PRESS    = 3'd2,
        REG_UPPER_RELEASE  = 3'd3,
        REG_LOWER_PRESS    = 3'd4,
        REG_LOWER_RELEASE  = 3'd5,
        REG_REPEAT_INITIAL = 3'd6,
        REG_REPEAT_NEXT    = 3'd7
    } t_reg_idx;

    typedef struct packed {
        logic [LVL_W-1:0]  pressed_level;
        logic [LVL_W-1:0]  step_up;
        logic [AXIS_W-1:0] upper_press;
        logic [AXIS_W-1:0] upper_release;
        logic [AXIS_W-1:0] lower_press;
        logic [AXIS_W-1:0] lower_release;
        logic [CNT_W-1:0]  repeat_initial;
        logic [CNT_W-1:0]  repeat_next;
    } t_cfg;

    localparam t_cfg CFG_RESET = '{
        pressed_level:  8'd10,
        step_up:        8'd1,
        upper_press:    12'd3000,
        upper_release:  12'd2500,
        lower_press:    12'd1000,
        lower_release:  12'd1500,
        repeat_initial: 16'd100,
        repeat_next:    16'd10
    };

endpackage

`default_nettype wire

// ----- design/button_debounce_hysteresis_autorepeat.sv -----
// an item waits in the input register and its result in the result register
// throughput: one item per cycle while the result is not stalled, with the
// state update combinational between the input register and result register
// a stalled result does not block intake until the input register is full
// synchronous active-low reset clears levels, held bits, repeat counters
// and both valid flags, and loads the configuration register defaults
// ----------------------------------------------------------------------------
// button_debounce_hysteresis_autorepeat
// polled button debouncer with joystick hysteresis and autorepeat presses
// ----------------------------------------------------------------------------
`default_nettype none

module button_debounce_hysteresis_autorepeat (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_cfg_we,
    input  wire logic [bdha_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  wire logic [bdha_pkg::CFG_DATA_W-1:0]   i_cfg_wdata,
    input  wire logic                              i_in_valid,
    output logic                                   o_in_ready,
    input  wire logic [bdha_pkg::RAW_W-1:0]        i_raw_buttons,
    input  wire logic [bdha_pkg::AXIS_W-1:0]       i_joy_x,
    input  wire logic [bdha_pkg::AXIS_W-1:0]       i_joy_y,
    output logic                                   o_out_valid,
    input  wire logic                              i_out_ready,
    output logic      [bdha_pkg::NUM_HELD-1:0]     o_held,
    output logic      [bdha_pkg::NUM_HELD-1:0]     o_presses
);

    bdha_pkg::t_cfg                    r_cfg;
    logic                              r_in_valid;
    logic [bdha_pkg::RAW_W-1:0]        r_raw;
    logic [bdha_pkg::AXIS_W-1:0]       r_jx;
    logic [bdha_pkg::AXIS_W-1:0]       r_jy;
    logic [bdha_pkg::NUM_HELD-1:0]     r_held;
    logic [bdha_pkg::NUM_HELD-1:0]     n_held;
    logic                              r_out_valid;
    logic [bdha_pkg::NUM_HELD-1:0]     r_out_held;
    logic [bdha_pkg::NUM_HELD-1:0]     r_out_presses;
    logic [bdha_pkg::NUM_HELD-1:0]     w_presses;
    logic [bdha_pkg::RAW_W-1:0]        w_btn_held;
    logic                              w_adv;

    assign w_adv      = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || w_adv;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= bdha_pkg::CFG_RESET;
        end else if (i_cfg_we) begin
            unique case (bdha_pkg::t_reg_idx'(i_cfg_idx))
                bdha_pkg::REG_PRESSED_LEVEL:
                    r_cfg.pressed_level <= i_cfg_wdata[bdha_pkg::LVL_W-1:0];
                bdha_pkg::REG_STEP_UP:
                    r_cfg.step_up <= i_cfg_wdata[bdha_pkg::LVL_W-1:0];
                bdha_pkg::REG_UPPER_PRESS:
                    r_cfg.upper_press <= i_cfg_wdata[bdha_pkg::AXIS_W-1:0];
                bdha_pkg::REG_UPPER_RELEASE:
                    r_cfg.upper_release <= i_cfg_wdata[bdha_pkg::AXIS_W-1:0];
                bdha_pkg::REG_LOWER_PRESS:
                    r_cfg.lower_press <= i_cfg_wdata[bdha_pkg::AXIS_W-1:0];
                bdha_pkg::REG_LOWER_RELEASE:
                    r_cfg.lower_release <= i_cfg_wdata[bdha_pkg::AXIS_W-1:0];
                bdha_pkg::REG_REPEAT_INITIAL:
                    r_cfg.repeat_initial <= i_cfg_wdata[bdha_pkg::CNT_W-1:0];
                bdha_pkg::REG_REPEAT_NEXT:
                    r_cfg.repeat_next <= i_cfg_wdata[bdha_pkg::CNT_W-1:0];
            endcase
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_raw <= i_raw_buttons;
            r_jx  <= i_joy_x;
            r_jy  <= i_joy_y;
        end
    end

    bdha_debounce u_debounce (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_adv),
        .i_cfg   (r_cfg),
        .i_raw   (r_raw),
        .i_held  (r_held[bdha_pkg::RAW_W-1:0]),
        .o_held  (w_btn_held)
    );

    bdha_axis u_axis_x (
        .i_cfg    (r_cfg),
        .i_value  (r_jx),
        .i_old_hi (r_held[bdha_pkg::BIT_RIGHT]),
        .i_old_lo (r_held[bdha_pkg::BIT_LEFT]),
        .o_hi     (n_held[bdha_pkg::BIT_RIGHT]),
        .o_lo     (n_held[bdha_pkg::BIT_LEFT])
    );

    bdha_axis u_axis_y (
        .i_cfg    (r_cfg),
        .i_value  (r_jy),
        .i_old_hi (r_held[bdha_pkg::BIT_UP]),
        .i_old_lo (r_held[bdha_pkg::BIT_DOWN]),
        .o_hi     (n_held[bdha_pkg::BIT_UP]),
        .o_lo     (n_held[bdha_pkg::BIT_DOWN])
    );

    assign n_held[bdha_pkg::RAW_W-1:0] = w_btn_held;

    bdha_repeat u_repeat (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (w_adv),
        .i_cfg      (r_cfg),
        .i_held_old (r_held),
        .i_held_new (n_held),
        .o_presses  (w_presses)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held <= '0;
        end else if (w_adv) begin
            r_held <= n_held;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_out_held    <= n_held;
            r_out_presses <= w_presses;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_held      = r_out_held;
    assign o_presses   = r_out_presses;

endmodule

`default_nettype wire

// ----- design/bdha_debounce.sv -----
// ----------------------------------------------------------------------------
// bdha_debounce
// integrating debouncer, one level register per button
// ----------------------------------------------------------------------------
`default_nettype none

module bdha_debounce (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_en,
    input  wire bdha_pkg::t_cfg               i_cfg,
    input  wire logic [bdha_pkg::RAW_W-1:0]   i_raw,
    input  wire logic [bdha_pkg::RAW_W-1:0]   i_held,
    output logic      [bdha_pkg::RAW_W-1:0]   o_held
);

    for (genvar g = 0; g < bdha_pkg::RAW_W; g++) begin : g_btn
        if (g < bdha_pkg::NUM_BUTTONS) begin : g_used
            logic [bdha_pkg::LVL_W-1:0] r_level;
            logic [bdha_pkg::LVL_W-1:0] n_level;
            logic [bdha_pkg::LVL_W:0]   w_sum;
            logic                       w_held;

            always_comb begin
                w_sum   = {1'b0, r_level} + {1'b0, i_cfg.step_up};
                n_level = r_level;
                w_held  = i_held[g];
                if (i_raw[g]) begin
                    if (w_sum >= {1'b0, i_cfg.pressed_level}) begin
                        n_level = i_cfg.pressed_level;
                        w_held  = 1'b1;
                    end else begin
                        n_level = w_sum[bdha_pkg::LVL_W-1:0];
                    end
                end else if (r_level <= bdha_pkg::STEP_DOWN) begin
                    n_level = '0;
                    w_held  = 1'b0;
                end else begin
                    n_level = r_level - bdha_pkg::STEP_DOWN;
                end
            end

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_level <= '0;
                end else if (i_en) begin
                    r_level <= n_level;
                end
            end

            assign o_held[g] = w_held;
        end else begin : g_unused
            assign o_held[g] = 1'b0;
        end
    end

endmodule

`default_nettype wire

// ----- design/bdha_axis.sv -----
// ----------------------------------------------------------------------------
// bdha_axis
// hysteresis thresholds of one joystick axis, clear wins over set
// ----------------------------------------------------------------------------
`default_nettype none

module bdha_axis (
    input  wire bdha_pkg::t_cfg                i_cfg,
    input  wire logic [bdha_pkg::AXIS_W-1:0]   i_value,
    input  wire logic                          i_old_hi,
    input  wire logic                          i_old_lo,
    output logic                               o_hi,
    output logic                               o_lo
);

    always_comb begin
        o_hi = i_old_hi;
        if (i_value > i_cfg.upper_press) begin
            o_hi = 1'b1;
        end
        if (i_value < i_cfg.upper_release) begin
            o_hi = 1'b0;
        end
        o_lo = i_old_lo;
        if (i_value < i_cfg.lower_press) begin
            o_lo = 1'b1;
        end
        if (i_value > i_cfg.lower_release) begin
            o_lo = 1'b0;
        end
    end

endmodule

`default_nettype wire

// ----- design/bdha_repeat.sv -----
// ----------------------------------------------------------------------------
// bdha_repeat
// edge detect and autorepeat, saturating hold count plus phase per bit
// ----------------------------------------------------------------------------
`default_nettype none

module bdha_repeat (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_en,
    input  wire bdha_pkg::t_cfg                  i_cfg,
    input  wire logic [bdha_pkg::NUM_HELD-1:0]   i_held_old,
    input  wire logic [bdha_pkg::NUM_HELD-1:0]   i_held_new,
    output logic      [bdha_pkg::NUM_HELD-1:0]   o_presses
);

    for (genvar g = 0; g < bdha_pkg::NUM_HELD; g++) begin : g_bit
        logic [bdha_pkg::CNT_W-1:0] r_count;
        logic [bdha_pkg::CNT_W-1:0] n_count;
        logic [bdha_pkg::CNT_W-1:0] r_phase;
        logic [bdha_pkg::CNT_W-1:0] n_phase;
        logic [bdha_pkg::CNT_W:0]   w_ph_inc;
        logic                       w_rep;

        always_comb begin
            w_ph_inc = {1'b0, r_phase} + {{bdha_pkg::CNT_W{1'b0}}, 1'b1};
            n_count  = r_count;
            n_phase  = r_phase;
            w_rep    = 1'b0;
            if (!i_held_new[g]) begin
                n_count = '0;
                n_phase = '0;
            end else if (r_count < i_cfg.repeat_initial) begin
                n_count = r_count + {{(bdha_pkg::CNT_W-1){1'b0}}, 1'b1};
                if (n_count == i_cfg.repeat_initial) begin
                    n_phase = '0;
                    w_rep   = 1'b1;
                end
            end else begin
                if (w_ph_inc >= {1'b0, i_cfg.repeat_next}) begin
                    n_phase = '0;
                end else begin
                    n_phase = w_ph_inc[bdha_pkg::CNT_W-1:0];
                end
                w_rep = (n_phase == '0);
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_count <= '0;
                r_phase <= '0;
            end else if (i_en) begin
                r_count <= n_count;
                r_phase <= n_phase;
            end
        end

        assign o_presses[g] = (i_held_new[g] & ~i_held_old[g]) | w_rep;
    end

endmodule

`default_nettype wire

// ----- design/bdha_checker.sv -----
// ----------------------------------------------------------------------------
// bdha_checker
// port-level checks for the button debouncer, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

module bdha_checker (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_in_valid,
    input  wire logic                              o_in_ready,
    input  wire logic [bdha_pkg::RAW_W-1:0]        i_raw_buttons,
    input  wire logic [bdha_pkg::AXIS_W-1:0]       i_joy_x,
    input  wire logic [bdha_pkg::AXIS_W-1:0]       i_joy_y,
    input  wire logic                              o_out_valid,
    input  wire logic                              i_out_ready,
    input  wire logic [bdha_pkg::NUM_HELD-1:0]     o_held,
    input  wire logic [bdha_pkg::NUM_HELD-1:0]     o_presses
);

    // a press is only reported on a bit that is held
    a_press_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> ((o_presses & ~o_held) == '0))
        else $error("press on a bit that is not held");

    // intake only stalls behind a waiting result
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> (o_out_valid && !i_out_ready))
        else $error("input stalled without a pending result");

    // no result straight out of reset
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=>
            (o_out_valid && $stable(o_held) && $stable(o_presses)))
        else $error("stalled result changed");

    // waiting input item holds
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_ready) |=>
            (i_in_valid && $stable(i_raw_buttons) && $stable(i_joy_x)
             && $stable(i_joy_y)))
        else $error("waiting input item changed");

endmodule

bind button_debounce_hysteresis_autorepeat bdha_checker u_bdha_checker (.*);

`default_nettype wire

// ----- tb/sv/button_debounce_hysteresis_autorepeat_test.sv -----
// ----------------------------------------------------------------------------
// button_debounce_hysteresis_autorepeat_test
// Drives polling ticks into the debouncer and checks every report against
// a cycle-free model of the debounce levels, axis hysteresis and autorepeat.
// The run covers several register settings, including both extremes. Both
// handshakes stall at random, except during one steady phase.
// ----------------------------------------------------------------------------
module button_debounce_hysteresis_autorepeat_test;
    timeunit 1ns;
    timeprecision 1ps;

    import bdha_pkg::*;

    localparam int CYCLE_LIMIT = 200000;

    typedef struct packed {
        logic [NUM_HELD-1:0] held;
        logic [NUM_HELD-1:0] presses;
    } t_report;

    typedef struct packed {
        logic [RAW_W-1:0]  raw;
        logic [AXIS_W-1:0] jx;
        logic [AXIS_W-1:0] jy;
    } t_tick;

    logic                  i_clk;
    logic                  i_rst_n       = 1'b0;
    logic                  i_cfg_we      = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx     = '0;
    logic [CFG_DATA_W-1:0] i_cfg_wdata   = '0;
    logic                  i_in_valid    = 1'b0;
    logic                  o_in_ready;
    logic [RAW_W-1:0]      i_raw_buttons = '0;
    logic [AXIS_W-1:0]     i_joy_x       = '0;
    logic [AXIS_W-1:0]     i_joy_y       = '0;
    logic                  o_out_valid;
    logic                  i_out_ready   = 1'b0;
    logic [NUM_HELD-1:0]   o_held;
    logic [NUM_HELD-1:0]   o_presses;

    button_debounce_hysteresis_autorepeat uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_wdata   (i_cfg_wdata),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_raw_buttons (i_raw_buttons),
        .i_joy_x       (i_joy_x),
        .i_joy_y       (i_joy_y),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_held        (o_held),
        .o_presses     (o_presses)
    );

    t_tick       tick_queue[$];
    t_report     pending_reports[$];
    t_tick       next_tick;
    t_report     front_report;
    logic        steady         = 1'b0;
    int unsigned mismatch_count = 0;
    int unsigned cycle_count    = 0;

    // model state
    t_cfg             cfg_m;
    logic [LVL_W-1:0] level_m [NUM_BUTTONS];
    logic [8:0]       held_m;
    int               hold_m  [NUM_HELD];
    int               phase_m [NUM_HELD];

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    function automatic t_report scan_controls(logic [RAW_W-1:0] raw, logic [AXIS_W-1:0] jx,
                                              logic [AXIS_W-1:0] jy);
        t_report           r;
        logic [8:0]        prev;
        logic [AXIS_W-1:0] v;
        int                sum;
        int                hi;
        int                lo;
        prev = held_m;
        for (int i = 0; i < NUM_BUTTONS; i++) begin
            if (raw[i]) begin
                sum = int'(level_m[i]) + int'(cfg_m.step_up);
                if (sum >= int'(cfg_m.pressed_level)) begin
                    sum = int'(cfg_m.pressed_level);
                    held_m[i] = 1'b1;
                end
                level_m[i] = sum[7:0];
            end else if (level_m[i] <= STEP_DOWN) begin
                level_m[i] = '0;
                held_m[i] = 1'b0;
            end else begin
                level_m[i] = level_m[i] - STEP_DOWN;
            end
        end
        for (int ax = 0; ax < 2; ax++) begin
            v  = (ax == 0) ? jx : jy;
            hi = (ax == 0) ? BIT_RIGHT : BIT_UP;
            lo = (ax == 0) ? BIT_LEFT : BIT_DOWN;
            if (v > cfg_m.upper_press)   held_m[hi] = 1'b1;
            if (v < cfg_m.upper_release) held_m[hi] = 1'b0;
            if (v < cfg_m.lower_press)   held_m[lo] = 1'b1;
            if (v > cfg_m.lower_release) held_m[lo] = 1'b0;
        end
        r.held    = held_m;
        r.presses = ~prev & held_m;
        for (int i = 0; i < NUM_HELD; i++) begin
            if (!held_m[i]) begin
                hold_m[i]  = 0;
                phase_m[i] = 0;
            end else if (hold_m[i] < int'(cfg_m.repeat_initial)) begin
                hold_m[i]++;
                if (hold_m[i] == int'(cfg_m.repeat_initial)) begin
                    phase_m[i]   = 0;
                    r.presses[i] = 1'b1;
                end
            end else begin
                phase_m[i]++;
                if (phase_m[i] >= int'(cfg_m.repeat_next)) phase_m[i] = 0;
                if (phase_m[i] == 0) r.presses[i] = 1'b1;
            end
        end
        return r;
    endfunction

    function automatic t_cfg make_cfg(int pl, int su, int upp, int upr, int lop, int lor,
                                      int ri, int rn);
        t_cfg c;
        c.pressed_level  = 8'(pl);
        c.step_up        = 8'(su);
        c.upper_press    = 12'(upp);
        c.upper_release  = 12'(upr);
        c.lower_press    = 12'(lop);
        c.lower_release  = 12'(lor);
        c.repeat_initial = 16'(ri);
        c.repeat_next    = 16'(rn);
        return c;
    endfunction

    function automatic t_cfg random_cfg();
        int upp;
        int lop;
        t_cfg c;
        upp = $urandom_range(2048, 4095);
        lop = $urandom_range(0, 2047);
        c = make_cfg(($urandom_range(9) == 0) ? 255 : $urandom_range(0, 6),
                     ($urandom_range(9) == 0) ? 0 : $urandom_range(1, 3),
                     upp, upp - $urandom_range(0, 600), lop, lop + $urandom_range(0, 600),
                     ($urandom_range(9) == 0) ? 65535 : $urandom_range(0, 10),
                     ($urandom_range(9) == 0) ? 65535 : $urandom_range(0, 6));
        if ($urandom_range(4) == 0) begin
            c.upper_press   = 12'($urandom);
            c.upper_release = 12'($urandom);
            c.lower_press   = 12'($urandom);
            c.lower_release = 12'($urandom);
        end
        return c;
    endfunction

    // samples near the thresholds and rails, where hysteresis matters, or at random
    function automatic logic [AXIS_W-1:0] axis_value();
        int v;
        case ($urandom_range(6))
            0:       v = 0;
            1:       v = 4095;
            2:       v = int'(cfg_m.upper_press) + int'($urandom_range(4)) - 2;
            3:       v = int'(cfg_m.upper_release) + int'($urandom_range(4)) - 2;
            4:       v = int'(cfg_m.lower_press) + int'($urandom_range(4)) - 2;
            5:       v = int'(cfg_m.lower_release) + int'($urandom_range(4)) - 2;
            default: v = int'($urandom_range(4095));
        endcase
        if (v < 0)    v = 0;
        if (v > 4095) v = 4095;
        return v[AXIS_W-1:0];
    endfunction

    task automatic queue_tick(input logic [RAW_W-1:0] raw, input logic [AXIS_W-1:0] jx,
                              input logic [AXIS_W-1:0] jy);
        t_tick t;
        t.raw = raw;
        t.jx  = jx;
        t.jy  = jy;
        tick_queue.push_back(t);
    endtask

    task automatic queue_random_ticks(input int count);
        int                left;
        int                run_len;
        logic [RAW_W-1:0]  pattern;
        logic [AXIS_W-1:0] x;
        logic [AXIS_W-1:0] y;
        left = count;
        while (left > 0) begin
            if ($urandom_range(5) == 0) begin
                queue_tick(5'($urandom), 12'($urandom), 12'($urandom));
                left--;
            end else begin
                run_len = $urandom_range(1, 24);
                pattern = 5'($urandom);
                x = axis_value();
                y = axis_value();
                for (int j = 0; j < run_len && left > 0; j++) begin
                    // occasional contact bounce on one button
                    if ($urandom_range(7) == 0)
                        queue_tick(pattern ^ (5'd1 << $urandom_range(4)), x, y);
                    else
                        queue_tick(pattern, x, y);
                    left--;
                end
            end
        end
    endtask

    task automatic write_reg(input t_reg_idx idx, input logic [15:0] val, input int width);
        logic [15:0] wd;
        wd = val;
        if (width < 16) wd = (16'($urandom) << width) | val;
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_wdata <= wd;
    endtask

    task automatic load_cfg(input t_cfg c);
        write_reg(REG_PRESSED_LEVEL, 16'(c.pressed_level), LVL_W);
        write_reg(REG_STEP_UP, 16'(c.step_up), LVL_W);
        write_reg(REG_UPPER_PRESS, 16'(c.upper_press), AXIS_W);
        write_reg(REG_UPPER_RELEASE, 16'(c.upper_release), AXIS_W);
        write_reg(REG_LOWER_PRESS, 16'(c.lower_press), AXIS_W);
        write_reg(REG_LOWER_RELEASE, 16'(c.lower_release), AXIS_W);
        write_reg(REG_REPEAT_INITIAL, c.repeat_initial, CNT_W);
        write_reg(REG_REPEAT_NEXT, c.repeat_next, CNT_W);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        cfg_m = c;
    endtask

    task automatic drain();
        while (tick_queue.size() != 0 || i_in_valid || pending_reports.size() != 0)
            @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    // driver
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && o_in_ready)
                pending_reports.push_back(scan_controls(i_raw_buttons, i_joy_x, i_joy_y));
            if (!i_in_valid || o_in_ready) begin
                if (tick_queue.size() != 0 && (steady || $urandom_range(99) >= 29)) begin
                    next_tick = tick_queue.pop_front();
                    i_in_valid    <= 1'b1;
                    i_raw_buttons <= next_tick.raw;
                    i_joy_x       <= next_tick.jx;
                    i_joy_y       <= next_tick.jy;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_reports.size() == 0) begin
                mismatch_count++;
                if (mismatch_count < 40)
                    $display("%0t: unexpected item held %03h presses %03h",
                             $time, o_held, o_presses);
            end else begin
                front_report = pending_reports.pop_front();
                if (o_held !== front_report.held) begin
                    mismatch_count++;
                    if (mismatch_count < 40)
                        $display("%0t: held expected %03h actual %03h",
                                 $time, front_report.held, o_held);
                end
                if (o_presses !== front_report.presses) begin
                    mismatch_count++;
                    if (mismatch_count < 40)
                        $display("%0t: presses expected %03h actual %03h",
                                 $time, front_report.presses, o_presses);
                end
            end
        end
        i_out_ready <= steady || ($urandom_range(99) >= 29);
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("** button_debounce_hysteresis_autorepeat: FAILED **");
            $finish;
        end
    end

    initial begin
        cfg_m  = CFG_RESET;
        held_m = '0;
        for (int i = 0; i < NUM_BUTTONS; i++) level_m[i] = '0;
        for (int i = 0; i < NUM_HELD; i++) begin
            hold_m[i]  = 0;
            phase_m[i] = 0;
        end
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // short debounce and repeat, boundary axis values
        load_cfg(make_cfg(3, 1, 3000, 2500, 1000, 1500, 3, 2));
        repeat (5) queue_tick(5'h1f, 12'd4095, 12'd0);
        repeat (2) queue_tick(5'h00, 12'd2048, 12'd2048);
        queue_tick(5'h1f, 12'd3001, 12'd999);
        queue_tick(5'h00, 12'd3000, 12'd1000);
        queue_tick(5'h15, 12'd2500, 12'd1500);
        queue_tick(5'h0a, 12'd2499, 12'd1501);
        queue_tick(5'h00, 12'd0, 12'd4095);
        drain();

        // crossed thresholds so clear wins, zero level, zero repeat registers
        load_cfg(make_cfg(0, 255, 1000, 3000, 3000, 1000, 0, 0));
        queue_tick(5'h1f, 12'd2000, 12'd2000);
        queue_tick(5'h15, 12'd4095, 12'd4095);
        queue_tick(5'h0a, 12'd0, 12'd0);
        repeat (3) queue_tick(5'h1f, 12'd4095, 12'd0);
        repeat (2) queue_tick(5'h00, 12'd2000, 12'd500);
        drain();

        // charge the levels high, then shrink pressed_level under them
        load_cfg(make_cfg(200, 100, 4095, 4095, 0, 0, 65535, 65535));
        repeat (3) queue_tick(5'h1f, 12'd4095, 12'd0);
        drain();
        load_cfg(make_cfg(5, 1, 3000, 2500, 1000, 1500, 2, 1));
        queue_tick(5'h05, 12'd4095, 12'd4095);
        repeat (2) queue_tick(5'h00, 12'd4095, 12'd4095);
        drain();

        for (int k = 0; k < 8; k++) begin
            steady = (k == 2);
            if (k == 1)
                load_cfg(make_cfg(255, 255, 4095, 4095, 4095, 4095, 65535, 65535));
            else if (k == 4)
                load_cfg(make_cfg(0, 0, 0, 0, 0, 0, 0, 0));
            else
                load_cfg(random_cfg());
            queue_random_ticks(210);
            drain();
        end
        steady = 1'b0;

        repeat (6) @(posedge i_clk);
        if (mismatch_count == 0 && pending_reports.size() == 0)
            $display("** button_debounce_hysteresis_autorepeat: PASSED **");
        else
            $display("** button_debounce_hysteresis_autorepeat: FAILED **");
        $finish;
    end

endmodule
